@@ design/sctstore_pkg.sv @@
// ----------------------------------------------------------------------------
// sctstore_pkg
// Shared constants and types for the sparse chunked tile store.
// ----------------------------------------------------------------------------
package sctstore_pkg;

    localparam int HASH_SLOTS  = 64;
    localparam int POOL_CHUNKS = 64;
    localparam int CHUNK_LOG2  = 4;

    localparam int ENTRY_COUNT = HASH_SLOTS + POOL_CHUNKS;
    localparam int ENTRY_W     = $clog2(ENTRY_COUNT);
    localparam int HASH_W      = $clog2(HASH_SLOTS);
    localparam int POOL_W      = $clog2(POOL_CHUNKS + 1);
    localparam int REL_W       = 2 * CHUNK_LOG2;
    localparam int CHUNK_TILES = 1 << REL_W;
    localparam int TILE_AW     = ENTRY_W + REL_W;
    localparam int TILE_DEPTH  = ENTRY_COUNT * CHUNK_TILES;

    localparam int XY_W      = 29;
    localparam int Z_W       = 25;
    localparam int COORD_W   = XY_W - CHUNK_LOG2;
    localparam int VALUE_W   = 32;
    localparam int S_DATA_W  = 120;
    localparam int M_DATA_W  = 32;
    localparam int M_USER_W  = 3;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_ABSENT = 2'd1,
        ST_FULL   = 2'd2
    } t_status;

    typedef struct packed {
        logic [Z_W-1:0]     cz;
        logic [COORD_W-1:0] cy;
        logic [COORD_W-1:0] cx;
    } t_key;

    typedef struct packed {
        t_key               key;
        logic [ENTRY_W-1:0] link;
    } t_kent;

endpackage

@@ design/sctstore_ram.sv @@
// ----------------------------------------------------------------------------
// sctstore_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module sctstore_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/sparse_chunked_tile_store.sv @@
// ----------------------------------------------------------------------------
// sparse_chunked_tile_store
// Sparse tile map of square chunks, found through a chained hash table.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel carries one request: tuser[0] = cmd (0 read, 1 write),
//   tdata = tile_x, tile_y, tile_z, write_value. The chunk key is hashed to
//   a head slot; collisions chain through a pool of chunks held in a key
//   RAM. A write that misses claims the head slot or appends a pool chunk.
//   Master channel returns read_value in tdata, is_empty and status in tuser.
//   A request steps through the head slot check, one key compare per chain
//   hop, the pool append and claim where a write needs them, and the tile
//   access. Every hop is one key RAM read; one request is in work at a time
//   and the next is taken once the sequencer is back in idle after the
//   result is loaded.
//   Tiles of a new chunk read as 1: a per-chunk row of written bits is
//   cleared when the chunk is claimed, so no fill sweep is needed.
//   Reset clears the entry valid bits and the pool count; no clearing pass.
//   A finished result sits in the output register; while the receiver
//   stalls, the next request can be taken and worked up to its result,
//   which then waits until the output register frees.
// ----------------------------------------------------------------------------
module sparse_chunked_tile_store (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // tile_x[28:0], tile_y[57:29], tile_z[82:58], write_value[114:83], zero pad
    input  logic [sctstore_pkg::S_DATA_W-1:0] i_s_tdata,
    // cmd[0]
    input  logic                             i_s_tuser,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // read_value[31:0]
    output logic [sctstore_pkg::M_DATA_W-1:0] o_m_tdata,
    // is_empty[0], status[2:1]
    output logic [sctstore_pkg::M_USER_W-1:0] o_m_tuser
);

    import sctstore_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HEAD,
        S_KEY,
        S_APPEND,
        S_ALLOC,
        S_TILE,
        S_DONE
    } t_state;

    t_state               r_state;
    logic                 r_cmd;
    t_key                 r_key;
    logic [REL_W-1:0]     r_rel;
    logic [VALUE_W-1:0]   r_wv;
    logic [ENTRY_W-1:0]   r_entry;
    logic [POOL_W-1:0]    r_pool_used;
    logic [ENTRY_COUNT-1:0] r_valid;
    logic [VALUE_W-1:0]   r_res_value;
    t_status              r_res_status;
    logic                 r_out_valid;
    logic [VALUE_W-1:0]   r_out_value;
    logic                 r_out_empty;
    t_status              r_out_status;

    logic                 accept;
    t_key                 in_key;
    logic [REL_W-1:0]     in_rel;
    logic [31:0]          hash_sum;
    logic [ENTRY_W-1:0]   n_entry;
    logic [REL_W-1:0]     n_rel;
    t_kent                key_q;
    logic                 key_we;
    t_kent                key_wdata;
    logic [CHUNK_TILES-1:0] row_q;
    logic                 row_we;
    logic [CHUNK_TILES-1:0] row_wdata;
    logic [VALUE_W-1:0]   tile_q;
    logic                 tile_we;
    logic [CHUNK_TILES-1:0] rel_bit;
    logic                 key_match;
    logic                 next_ok;
    logic                 pool_free;
    logic [ENTRY_W-1:0]   new_entry;
    logic [VALUE_W-1:0]   tile_rd;

    // unpack request and hash the chunk key
    assign accept        = i_s_tvalid && o_s_tready;
    assign o_s_tready    = (r_state == S_IDLE);
    assign in_key.cx     = i_s_tdata[CHUNK_LOG2 +: COORD_W];
    assign in_key.cy     = i_s_tdata[XY_W + CHUNK_LOG2 +: COORD_W];
    assign in_key.cz     = i_s_tdata[2*XY_W +: Z_W];
    assign in_rel        = {i_s_tdata[XY_W +: CHUNK_LOG2], i_s_tdata[0 +: CHUNK_LOG2]};
    assign hash_sum      = 32'(in_key.cx) * 32'd19 + 32'(in_key.cy) * 32'd7
                         + 32'(in_key.cz) * 32'd3;

    // chain walk decisions
    assign key_match  = (key_q.key == r_key);
    assign next_ok    = (key_q.link != '0) && r_valid[key_q.link];
    assign pool_free  = (r_pool_used < POOL_W'(POOL_CHUNKS));
    assign new_entry  = ENTRY_W'(HASH_SLOTS) + ENTRY_W'(r_pool_used);
    assign rel_bit    = CHUNK_TILES'(1) << r_rel;
    assign tile_rd    = row_q[r_rel] ? tile_q : VALUE_W'(1);

    // next entry address drives every RAM read
    always_comb begin
        n_entry = r_entry;
        n_rel   = r_rel;
        if (accept) begin
            n_entry = ENTRY_W'(hash_sum[HASH_W-1:0]);
            n_rel   = in_rel;
        end else if (r_state == S_KEY && !key_match && next_ok) begin
            n_entry = key_q.link;
        end else if (r_state == S_APPEND) begin
            n_entry = new_entry;
        end
    end

    // RAM write controls
    always_comb begin
        key_we    = 1'b0;
        key_wdata = '{key: r_key, link: '0};
        row_we    = 1'b0;
        row_wdata = rel_bit;
        tile_we   = 1'b0;
        unique case (r_state)
            S_APPEND: begin
                key_we    = 1'b1;
                key_wdata = '{key: key_q.key, link: new_entry};
            end
            S_ALLOC: begin
                key_we  = 1'b1;
                row_we  = 1'b1;
                tile_we = 1'b1;
            end
            S_TILE: begin
                row_we    = r_cmd;
                row_wdata = row_q | rel_bit;
                tile_we   = r_cmd;
            end
            default: begin
            end
        endcase
    end

    sctstore_ram #(.WIDTH($bits(t_kent)), .DEPTH(ENTRY_COUNT)) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (r_entry),
        .i_wdata (key_wdata),
        .i_raddr (n_entry),
        .o_rdata (key_q)
    );

    sctstore_ram #(.WIDTH(CHUNK_TILES), .DEPTH(ENTRY_COUNT)) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (row_we),
        .i_waddr (r_entry),
        .i_wdata (row_wdata),
        .i_raddr (n_entry),
        .o_rdata (row_q)
    );

    sctstore_ram #(.WIDTH(VALUE_W), .DEPTH(TILE_DEPTH)) u_tile_ram (
        .i_clk   (i_clk),
        .i_we    (tile_we),
        .i_waddr ({r_entry, r_rel}),
        .i_wdata (r_wv),
        .i_raddr ({n_entry, n_rel}),
        .o_rdata (tile_q)
    );

    // sequencer, state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pool_used <= '0;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_entry <= n_entry;
            // drop the taken result unless a new one is loaded this cycle
            if (r_out_valid && i_m_tready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_cmd   <= i_s_tuser;
                        r_key   <= in_key;
                        r_rel   <= in_rel;
                        r_wv    <= i_s_tdata[XY_W*2 + Z_W +: VALUE_W];
                        r_state <= S_HEAD;
                    end
                end
                S_HEAD: begin
                    if (r_valid[r_entry]) begin
                        r_state <= S_KEY;
                    end else if (r_cmd) begin
                        r_state <= S_ALLOC;
                    end else begin
                        r_res_value  <= '0;
                        r_res_status <= ST_ABSENT;
                        r_state      <= S_DONE;
                    end
                end
                S_KEY: begin
                    if (key_match) begin
                        r_state <= S_TILE;
                    end else if (!next_ok) begin
                        if (r_cmd && pool_free) begin
                            r_state <= S_APPEND;
                        end else begin
                            r_res_value  <= '0;
                            r_res_status <= r_cmd ? ST_FULL : ST_ABSENT;
                            r_state      <= S_DONE;
                        end
                    end
                end
                S_APPEND: begin
                    r_pool_used <= r_pool_used + POOL_W'(1);
                    r_state     <= S_ALLOC;
                end
                S_ALLOC: begin
                    r_valid[r_entry] <= 1'b1;
                    r_res_value      <= r_wv;
                    r_res_status     <= ST_OK;
                    r_state          <= S_DONE;
                end
                S_TILE: begin
                    r_res_value  <= r_cmd ? r_wv : tile_rd;
                    r_res_status <= ST_OK;
                    r_state      <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_valid || i_m_tready) begin
                        r_out_valid  <= 1'b1;
                        r_out_value  <= r_res_value;
                        r_out_empty  <= (r_res_value == VALUE_W'(1))
                                     || (r_res_value == VALUE_W'(3))
                                     || (r_res_value == VALUE_W'(4));
                        r_out_status <= r_res_status;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_value;
    assign o_m_tuser  = {r_out_status, r_out_empty};

    // checks
    a_pool_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pool_used <= POOL_W'(POOL_CHUNKS))
        else $error("pool count beyond pool size");

    a_one_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !o_s_tready)
        else $error("request taken while one is in work");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[2:1] != ST_OK) |-> (o_m_tdata == '0 && !o_m_tuser[0]))
        else $error("miss result carries data");

    a_append_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_APPEND) |-> (pool_free && !r_valid[new_entry]))
        else $error("append into used pool chunk");

endmodule

@@ sim/sparse_chunked_tile_store_test.sv @@
// ----------------------------------------------------------------------------
// sparse_chunked_tile_store_test
// Drives read and write requests into the tile store and compares every
// result against a behavioral chained-hash map kept inside the bench.
// ----------------------------------------------------------------------------
module sparse_chunked_tile_store_test;
    import sctstore_pkg::*;

    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    typedef struct packed {
        logic        cmd;
        logic [28:0] tx;
        logic [28:0] ty;
        logic [24:0] tz;
        logic [31:0] wv;
    } t_request;

    typedef struct packed {
        logic [31:0] value;
        logic        empty;
        t_status     status;
    } t_outcome;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_s_tvalid;
    logic                o_s_tready;
    logic [S_DATA_W-1:0] i_s_tdata;
    logic                i_s_tuser;
    logic                o_m_tvalid;
    logic                i_m_tready;
    logic [M_DATA_W-1:0] o_m_tdata;
    logic [M_USER_W-1:0] o_m_tuser;

    sparse_chunked_tile_store u_dut (.*);

    // map state
    bit          map_valid [ENTRY_COUNT];
    logic [24:0] map_cx    [ENTRY_COUNT];
    logic [24:0] map_cy    [ENTRY_COUNT];
    logic [24:0] map_cz    [ENTRY_COUNT];
    int          map_link  [ENTRY_COUNT];
    logic [31:0] tile_vals [int];
    int          pool_count;

    t_request pending_reqs [$];
    t_outcome expected_results [$];
    int  mismatch_count;
    int  send_gap;
    int  recv_gap;
    bit  stimulus_done;

    // Claim an entry for a chunk; its tiles read back as 1.
    task automatic claim_chunk(int e, logic [24:0] cx, logic [24:0] cy, logic [24:0] cz);
        map_valid[e] = 1;
        map_cx[e] = cx;
        map_cy[e] = cy;
        map_cz[e] = cz;
        map_link[e] = 0;
        for (int i = 0; i < CHUNK_TILES; i++) tile_vals[e * CHUNK_TILES + i] = 32'd1;
    endtask

    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // Apply one request to the map and return its outcome.
    task automatic apply_tile_access(input t_request rq, output t_outcome res);
        logic [24:0] cx, cy, cz;
        logic [31:0] hash;
        int  e, nx, rel, addr;
        bit  found;
        cx = rq.tx[28:CHUNK_LOG2];
        cy = rq.ty[28:CHUNK_LOG2];
        cz = rq.tz;
        rel = 32'({rq.ty[CHUNK_LOG2-1:0], rq.tx[CHUNK_LOG2-1:0]});
        hash = 32'd19 * cx + 32'd7 * cy + 32'd3 * cz;
        e = hash % HASH_SLOTS;
        found = 0;
        if (!map_valid[e]) begin
            if (rq.cmd == CMD_WRITE) begin
                claim_chunk(e, cx, cy, cz);
                found = 1;
            end
        end else begin
            for (int hops = 0; hops < ENTRY_COUNT; hops++) begin
                if (map_cx[e] == cx && map_cy[e] == cy && map_cz[e] == cz) begin
                    found = 1;
                    break;
                end
                nx = map_link[e];
                if (nx == 0 || nx >= ENTRY_COUNT || !map_valid[nx]) begin
                    if (rq.cmd == CMD_WRITE && pool_count < POOL_CHUNKS) begin
                        map_link[e] = HASH_SLOTS + pool_count;
                        e = HASH_SLOTS + pool_count;
                        pool_count++;
                        claim_chunk(e, cx, cy, cz);
                        found = 1;
                    end
                    break;
                end
                e = nx;
            end
        end
        if (found) begin
            addr = e * CHUNK_TILES + rel;
            if (rq.cmd == CMD_WRITE) tile_vals[addr] = rq.wv;
            res.value = tile_vals[addr];
            res.status = ST_OK;
        end else begin
            res.value = 32'd0;
            res.status = (rq.cmd == CMD_WRITE) ? ST_FULL : ST_ABSENT;
        end
        res.empty = (res.value == 1 || res.value == 3 || res.value == 4);
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0h want %0h", what, got, want);
        mismatch_count++;
    endtask

    function automatic t_request make_req(logic cmd, logic [28:0] tx, logic [28:0] ty,
                                          logic [24:0] tz, logic [31:0] wv);
        t_request rq;
        rq.cmd = cmd; rq.tx = tx; rq.ty = ty; rq.tz = tz; rq.wv = wv;
        return rq;
    endfunction

    // clock
    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    // timeout
    initial begin
        #2000000;
        $display("simulation failed");
        $finish;
    end

    // request driver
    always @(posedge i_clk) begin
        t_outcome res;
        if (!i_rst_n) begin
            i_s_tvalid <= 0;
            send_gap <= 0;
        end else if (!i_s_tvalid || o_s_tready) begin
            if (i_s_tvalid) apply_tile_access(pending_reqs.pop_front(), res);
            if (i_s_tvalid) expected_results.push_back(res);
            if (send_gap > 0 || pending_reqs.size() == 0) begin
                i_s_tvalid <= 0;
                if (send_gap > 0) send_gap <= send_gap - 1;
            end else begin
                i_s_tvalid <= 1;
                i_s_tdata <= {5'd0, pending_reqs[0].wv, pending_reqs[0].tz,
                              pending_reqs[0].ty, pending_reqs[0].tx};
                i_s_tuser <= pending_reqs[0].cmd;
                send_gap <= gap_length();
            end
        end
    end

    // result monitor and receiver stalls
    always @(posedge i_clk) begin
        t_outcome want;
        if (!i_rst_n) begin
            i_m_tready <= 0;
            recv_gap <= 0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result", o_m_tdata, 32'd0);
                end else begin
                    want = expected_results.pop_front();
                    if (o_m_tdata !== want.value)
                        report_mismatch("read_value", o_m_tdata, want.value);
                    if (o_m_tuser[0] !== want.empty)
                        report_mismatch("is_empty", 32'(o_m_tuser[0]), 32'(want.empty));
                    if (o_m_tuser[2:1] !== want.status)
                        report_mismatch("status", 32'(o_m_tuser[2:1]), 32'(want.status));
                end
            end
            if (recv_gap > 0) begin
                i_m_tready <= 0;
                recv_gap <= recv_gap - 1;
            end else begin
                i_m_tready <= 1;
                recv_gap <= stimulus_done ? 0 : gap_length();
            end
        end
    end

    // stimulus and end of run
    initial begin
        logic [28:0] tx, ty;
        logic [24:0] tz;
        int n, r, k;
        logic [28:0] hot_x [8];
        logic [28:0] hot_y [8];
        logic [24:0] hot_z [8];
        i_rst_n = 0;
        i_s_tvalid = 0;
        i_s_tdata = '0;
        i_s_tuser = 0;
        i_m_tready = 0;
        mismatch_count = 0;
        pool_count = 0;
        stimulus_done = 0;
        foreach (map_valid[i]) begin
            map_valid[i] = 0;
            map_link[i] = 0;
        end

        // directed: absent read, claim, extremes, empty flag values
        pending_reqs.push_back(make_req(CMD_READ, '0, '0, '0, '1));
        pending_reqs.push_back(make_req(CMD_WRITE, '0, '0, '0, 32'd3));
        pending_reqs.push_back(make_req(CMD_READ, '0, '0, '0, '0));
        pending_reqs.push_back(make_req(CMD_READ, 29'd15, 29'd15, '0, '0));
        pending_reqs.push_back(make_req(CMD_WRITE, '1, '1, '1, '1));
        pending_reqs.push_back(make_req(CMD_READ, '1, '1, '1, '0));
        pending_reqs.push_back(make_req(CMD_WRITE, 29'd1, 29'd2, '0, 32'd4));
        pending_reqs.push_back(make_req(CMD_WRITE, 29'd3, 29'd2, '0, 32'd2));
        pending_reqs.push_back(make_req(CMD_WRITE, 29'd5, 29'd2, '0, 32'd0));
        // chunk x=64 hashes to the same head slot as chunk x=0: chains
        pending_reqs.push_back(make_req(CMD_READ, 29'd1024, '0, '0, '0));
        pending_reqs.push_back(make_req(CMD_WRITE, 29'd1024, '0, '0, 32'd1));
        pending_reqs.push_back(make_req(CMD_WRITE, 29'd2048, '0, '0, 32'h8000_0000));
        pending_reqs.push_back(make_req(CMD_READ, 29'd2048, '0, '0, '0));
        pending_reqs.push_back(make_req(CMD_READ, 29'd3072, '0, '0, '0));

        // random: mostly revisits of a few hot chunks, some spread wide
        for (int i = 0; i < 8; i++) begin
            hot_x[i] = 29'($urandom());
            hot_y[i] = 29'($urandom());
            hot_z[i] = 25'($urandom());
        end
        for (n = 0; n < 750; n++) begin
            r = $urandom_range(0, 99);
            k = $urandom_range(0, 7);
            if (r < 60) begin
                tx = {hot_x[k][28:4], 4'($urandom())};
                ty = {hot_y[k][28:4], 4'($urandom())};
                tz = hot_z[k];
            end else if (r < 85) begin
                // small coordinates crowd many chunks onto the head slots into long chains
                tx = 29'($urandom_range(0, 4095));
                ty = 29'($urandom_range(0, 255));
                tz = 25'($urandom_range(0, 3));
            end else begin
                tx = 29'($urandom());
                ty = 29'($urandom());
                tz = 25'($urandom());
            end
            pending_reqs.push_back(make_req(1'($urandom_range(0, 1)), tx, ty, tz,
                $urandom_range(0, 3) == 0 ? 32'($urandom_range(0, 5)) : 32'($urandom())));
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;

        wait (pending_reqs.size() == 0 && !i_s_tvalid);
        stimulus_done = 1;
        wait (expected_results.size() == 0);
        repeat (50) @(posedge i_clk);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule

@@ sparse_chunked_tile_store.f @@
design/sctstore_pkg.sv
design/sctstore_ram.sv
design/sparse_chunked_tile_store.sv
sim/sparse_chunked_tile_store_test.sv
